// File: design/bca_pkg.sv
// Shared types, constants and fixed-point helper functions of the bicomplex
// arithmetic unit. Every other design file refers to this package by scoped names.
package bca_pkg;

	localparam int unsigned QW        = 32;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned PROD_W    = 2 * QW;
	localparam int unsigned NUM_W     = QW + FRAC_W;
	localparam int unsigned FRONT_LAT = 5;
	localparam int unsigned PRE_LAT   = 3;
	localparam int unsigned DIV_ITER  = NUM_W;
	localparam int unsigned DIV_LAT   = DIV_ITER + 2;
	localparam int unsigned PIPE_LAT  = FRONT_LAT + PRE_LAT + DIV_LAT;
	localparam int unsigned CNT_W     = $clog2(PIPE_LAT + 2);

	typedef logic signed [QW-1:0] q_t;

	localparam q_t QMAX = {1'b0, {(QW-1){1'b1}}};
	localparam q_t QMIN = {1'b1, {(QW-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef struct packed {
		q_t re;
		q_t im;
	} cpx_t;

	typedef struct packed {
		cpx_t h1;
		cpx_t h2;
	} bcx_t;

	typedef struct packed {
		logic sat;
		q_t   val;
	} qres_t;

	typedef struct packed {
		logic sat;
		cpx_t val;
	} cres_t;

	// Side information that travels along with the division path.
	typedef struct packed {
		kind_t kind;
		bcx_t  res;
		logic  sat_res;
		logic  sat_div;
	} side_t;

	// Complex operands of the inner division stage.
	typedef struct packed {
		cpx_t den;
		cpx_t n1;
		cpx_t t;
	} divop_t;

	typedef struct packed {
		bcx_t r;
		logic sat;
		logic dz;
	} out_word_t;

	function automatic qres_t q_addsub(input q_t a, input q_t b, input logic sub);
		logic signed [QW:0] s;
		qres_t r;
		s = sub ? ({a[QW-1], a} - {b[QW-1], b}) : ({a[QW-1], a} + {b[QW-1], b});
		r.sat = (s[QW] != s[QW-1]);
		if (r.sat) begin
			r.val = s[QW] ? QMIN : QMAX;
		end else begin
			r.val = s[QW-1:0];
		end
		return r;
	endfunction

	function automatic cres_t c_addsub(input cpx_t a, input cpx_t b, input logic sub);
		qres_t re;
		qres_t im;
		cres_t r;
		re = q_addsub(a.re, b.re, sub);
		im = q_addsub(a.im, b.im, sub);
		r.sat    = re.sat | im.sat;
		r.val.re = re.val;
		r.val.im = im.val;
		return r;
	endfunction

	// Applies a sign to a magnitude and clamps it to the signed 32-bit range.
	function automatic qres_t q_sign_clamp(input logic [NUM_W-1:0] m, input logic neg);
		logic [NUM_W-1:0] lim;
		qres_t r;
		lim = {{(NUM_W-QW){1'b0}}, neg, {(QW-1){~neg}}};
		r.sat = (m > lim);
		if (r.sat) begin
			r.val = neg ? QMIN : QMAX;
		end else if (neg) begin
			r.val = QW'(-m[QW-1:0]);
		end else begin
			r.val = m[QW-1:0];
		end
		return r;
	endfunction

	// Rounds a full product to Q16.16, ties away from zero, then saturates.
	function automatic qres_t q_round(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [NUM_W-1:0]  m;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		m   = NUM_W'((mag + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W);
		return q_sign_clamp(m, p[PROD_W-1]);
	endfunction

endpackage

// File: design/bca_if.sv
// Valid/ready channel interfaces of the bicomplex arithmetic unit.
// Depends on bca_pkg for the component type.
interface bca_in_if;
	logic          valid;
	logic          ready;
	logic [1:0]    kind;
	bca_pkg::q_t   a_rr;
	bca_pkg::q_t   a_ri;
	bca_pkg::q_t   a_ir;
	bca_pkg::q_t   a_ii;
	bca_pkg::q_t   b_rr;
	bca_pkg::q_t   b_ri;
	bca_pkg::q_t   b_ir;
	bca_pkg::q_t   b_ii;

	modport source (output valid, kind, a_rr, a_ri, a_ir, a_ii, b_rr, b_ri, b_ir, b_ii,
		input ready);
	modport sink (input valid, kind, a_rr, a_ri, a_ir, a_ii, b_rr, b_ri, b_ir, b_ii,
		output ready);
endinterface

interface bca_out_if;
	logic        valid;
	logic        ready;
	bca_pkg::q_t r_rr;
	bca_pkg::q_t r_ri;
	bca_pkg::q_t r_ir;
	bca_pkg::q_t r_ii;
	logic        saturated;
	logic        div_by_zero;

	modport source (output valid, r_rr, r_ri, r_ir, r_ii, saturated, div_by_zero,
		input ready);
	modport sink (input valid, r_rr, r_ri, r_ir, r_ii, saturated, div_by_zero,
		output ready);
endinterface

// File: design/bicomplex_arithmetic_unit.sv
// Bicomplex arithmetic unit, top level.
// Uses bca_pkg, the channel interfaces in bca_if, bca_front, bca_cdiv_pre and bca_div.
//
// The operand channel carries kind and the two bicomplex operands a and b, each four
// signed Q16.16 components; the result channel carries the four result components
// and the saturated and div_by_zero flags. A word moves when valid and ready are
// both high. Kind selects a+b, a-b, a*b or a/b.
//
// Every operation runs through the same pipeline of 58 register stages: five for the
// outer products and sums, three for the inner division set-up, and fifty in each of
// four dividers, which produce one quotient bit per iteration stage. One operand word
// can be taken in every cycle while the skid register is empty.
//
// A one-word skid register sits behind the last stage. When the receiver holds ready
// low, the next finished word parks there and the whole pipeline then holds still;
// operand ready drops only while the skid register is full. Nothing is lost or
// repeated across a stall. Reset clears the stage valid bits and the skid full flag;
// the datapath registers and the held skid word are not reset.
module bicomplex_arithmetic_unit (
	input logic       clk,
	input logic       arst_n,
	bca_in_if.sink    operand,
	bca_out_if.source result
);

	localparam int unsigned PIPE_LAT = bca_pkg::PIPE_LAT;
	localparam int unsigned DIV_LAT  = bca_pkg::DIV_LAT;

	logic                  en;
	logic [PIPE_LAT:1]     v_s;
	logic                  skid_full_q;
	bca_pkg::out_word_t    skid_q;
	bca_pkg::out_word_t    out_w;
	bca_pkg::out_word_t    sel_w;

	bca_pkg::bcx_t         a_in, b_in;
	bca_pkg::side_t        side_s5, side_s8;
	bca_pkg::divop_t       op_s5;
	bca_pkg::q_t           den_s8;
	bca_pkg::bcx_t         num_s8;
	bca_pkg::q_t           lane_num [4];
	bca_pkg::q_t           quo      [4];
	logic [3:0]            dsat, ddz;
	bca_pkg::side_t        side_dl  [1:DIV_LAT];

	assign en            = ~skid_full_q;
	assign operand.ready = en;

	assign a_in = {operand.a_rr, operand.a_ri, operand.a_ir, operand.a_ii};
	assign b_in = {operand.b_rr, operand.b_ri, operand.b_ir, operand.b_ii};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[PIPE_LAT-1:1], operand.valid};
		end
	end

	bca_front u_front (
		.clk  (clk),
		.en   (en),
		.kind (bca_pkg::kind_t'(operand.kind)),
		.a    (a_in),
		.b    (b_in),
		.side (side_s5),
		.op   (op_s5)
	);

	bca_cdiv_pre u_pre (
		.clk      (clk),
		.en       (en),
		.op       (op_s5),
		.side_in  (side_s5),
		.den      (den_s8),
		.num      (num_s8),
		.side_out (side_s8)
	);

	assign lane_num[0] = num_s8.h1.re;
	assign lane_num[1] = num_s8.h1.im;
	assign lane_num[2] = num_s8.h2.re;
	assign lane_num[3] = num_s8.h2.im;

	for (genvar g = 0; g < 4; g++) begin : g_lane
		bca_div u_div (
			.clk (clk),
			.en  (en),
			.num (lane_num[g]),
			.den (den_s8),
			.quo (quo[g]),
			.sat (dsat[g]),
			.dz  (ddz[g])
		);
	end

	// Side information follows the dividers stage by stage.
	always_ff @(posedge clk) begin
		if (en) begin
			side_dl[1] <= side_s8;
			for (int k = 2; k <= DIV_LAT; k++) begin
				side_dl[k] <= side_dl[k-1];
			end
		end
	end

	always_comb begin
		if (side_dl[DIV_LAT].kind == bca_pkg::KIND_DIV) begin
			out_w.r   = {quo[0], quo[1], quo[2], quo[3]};
			out_w.sat = side_dl[DIV_LAT].sat_div | (|dsat);
			out_w.dz  = |ddz;
		end else begin
			out_w.r   = side_dl[DIV_LAT].res;
			out_w.sat = side_dl[DIV_LAT].sat_res;
			out_w.dz  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (result.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (v_s[PIPE_LAT] && !result.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_q <= out_w;
		end
	end

	assign sel_w              = skid_full_q ? skid_q : out_w;
	assign result.valid       = skid_full_q | v_s[PIPE_LAT];
	assign result.r_rr        = sel_w.r.h1.re;
	assign result.r_ri        = sel_w.r.h1.im;
	assign result.r_ir        = sel_w.r.h2.re;
	assign result.r_ii        = sel_w.r.h2.im;
	assign result.saturated   = sel_w.sat;
	assign result.div_by_zero = sel_w.dz;

endmodule

// File: design/bca_front.sv
// Outer level of the bicomplex unit: operand register, 24 products, rounding,
// complex products and the outer add/sub combination. Depends on bca_pkg.
module bca_front (
	input  logic            clk,
	input  logic            en,
	input  bca_pkg::kind_t  kind,
	input  bca_pkg::bcx_t   a,
	input  bca_pkg::bcx_t   b,
	output bca_pkg::side_t  side,
	output bca_pkg::divop_t op
);

	localparam int unsigned NCM = 6;

	bca_pkg::kind_t kind_s1, kind_s2, kind_s3, kind_s4;
	bca_pkg::bcx_t  a_s1, b_s1;
	bca_pkg::bcx_t  as_s2, as_s3, as_s4;
	logic           as_sat_s2, as_sat_s3, as_sat_s4;

	logic signed [bca_pkg::PROD_W-1:0] prod_s2 [NCM][4];
	bca_pkg::q_t                       rp_s3   [NCM][4];
	logic [NCM-1:0]                    sat_s3;
	bca_pkg::cpx_t                     cm_s4   [NCM];
	logic [NCM-1:0]                    sat_s4;

	bca_pkg::side_t  side_s5;
	bca_pkg::divop_t op_s5;

	bca_pkg::cpx_t  x [NCM];
	bca_pkg::cpx_t  y [NCM];
	bca_pkg::cres_t as1, as2;
	bca_pkg::qres_t rnd [NCM][4];
	bca_pkg::qres_t cre [NCM];
	bca_pkg::qres_t cim [NCM];
	bca_pkg::cres_t mh1, mh2, dden, dt, dn1;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			a_s1    <= a;
			b_s1    <= b;
		end
	end

	// Complex product pairs: x1*y1, x2*y2, x1*y2, x2*y1, y1*y1, y2*y2.
	always_comb begin
		x[0] = a_s1.h1; y[0] = b_s1.h1;
		x[1] = a_s1.h2; y[1] = b_s1.h2;
		x[2] = a_s1.h1; y[2] = b_s1.h2;
		x[3] = a_s1.h2; y[3] = b_s1.h1;
		x[4] = b_s1.h1; y[4] = b_s1.h1;
		x[5] = b_s1.h2; y[5] = b_s1.h2;
		as1 = bca_pkg::c_addsub(a_s1.h1, b_s1.h1, kind_s1 == bca_pkg::KIND_SUB);
		as2 = bca_pkg::c_addsub(a_s1.h2, b_s1.h2, kind_s1 == bca_pkg::KIND_SUB);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2   <= kind_s1;
			as_s2     <= {as1.val, as2.val};
			as_sat_s2 <= as1.sat | as2.sat;
			for (int i = 0; i < NCM; i++) begin
				prod_s2[i][0] <= x[i].re * y[i].re;
				prod_s2[i][1] <= x[i].im * y[i].im;
				prod_s2[i][2] <= x[i].re * y[i].im;
				prod_s2[i][3] <= x[i].im * y[i].re;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NCM; i++) begin
			for (int j = 0; j < 4; j++) begin
				rnd[i][j] = bca_pkg::q_round(prod_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3   <= kind_s2;
			as_s3     <= as_s2;
			as_sat_s3 <= as_sat_s2;
			for (int i = 0; i < NCM; i++) begin
				for (int j = 0; j < 4; j++) begin
					rp_s3[i][j] <= rnd[i][j].val;
				end
				sat_s3[i] <= rnd[i][0].sat | rnd[i][1].sat | rnd[i][2].sat | rnd[i][3].sat;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NCM; i++) begin
			cre[i] = bca_pkg::q_addsub(rp_s3[i][0], rp_s3[i][1], 1'b1);
			cim[i] = bca_pkg::q_addsub(rp_s3[i][2], rp_s3[i][3], 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4   <= kind_s3;
			as_s4     <= as_s3;
			as_sat_s4 <= as_sat_s3;
			for (int i = 0; i < NCM; i++) begin
				cm_s4[i].re <= cre[i].val;
				cm_s4[i].im <= cim[i].val;
				sat_s4[i]   <= sat_s3[i] | cre[i].sat | cim[i].sat;
			end
		end
	end

	always_comb begin
		mh1  = bca_pkg::c_addsub(cm_s4[0], cm_s4[1], 1'b1);
		mh2  = bca_pkg::c_addsub(cm_s4[2], cm_s4[3], 1'b0);
		dden = bca_pkg::c_addsub(cm_s4[4], cm_s4[5], 1'b0);
		dt   = bca_pkg::c_addsub(cm_s4[3], cm_s4[2], 1'b1);
		dn1  = bca_pkg::c_addsub(cm_s4[0], cm_s4[1], 1'b0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5.kind <= kind_s4;
			if (kind_s4 == bca_pkg::KIND_MUL) begin
				side_s5.res     <= {mh1.val, mh2.val};
				side_s5.sat_res <= (|sat_s4[3:0]) | mh1.sat | mh2.sat;
			end else begin
				side_s5.res     <= as_s4;
				side_s5.sat_res <= as_sat_s4;
			end
			side_s5.sat_div <= (|sat_s4) | dden.sat | dt.sat | dn1.sat;
			op_s5.den       <= dden.val;
			op_s5.n1        <= dn1.val;
			op_s5.t         <= dt.val;
		end
	end

	assign side = side_s5;
	assign op   = op_s5;

endmodule

// File: design/bca_cdiv_pre.sv
// Inner complex division, first part: squares and cross products with the
// complex divisor, rounding, and the real divisor and four numerators. Depends on bca_pkg.
module bca_cdiv_pre (
	input  logic            clk,
	input  logic            en,
	input  bca_pkg::divop_t op,
	input  bca_pkg::side_t  side_in,
	output bca_pkg::q_t     den,
	output bca_pkg::bcx_t   num,
	output bca_pkg::side_t  side_out
);

	localparam int unsigned NP = 10;

	logic signed [bca_pkg::PROD_W-1:0] pp_s6 [NP];
	bca_pkg::q_t                       rp_s7 [NP];
	logic                              sat_s7;
	bca_pkg::side_t                    side_s6, side_s7, side_s8;
	bca_pkg::q_t                       den_s8;
	bca_pkg::bcx_t                     num_s8;

	bca_pkg::qres_t rnd [NP];
	bca_pkg::qres_t dsum, n1re, n1im, tre, tim;
	logic           rsat;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6  <= side_in;
			pp_s6[0] <= op.den.re * op.den.re;
			pp_s6[1] <= op.den.im * op.den.im;
			pp_s6[2] <= op.n1.re * op.den.re;
			pp_s6[3] <= op.n1.im * op.den.im;
			pp_s6[4] <= op.n1.im * op.den.re;
			pp_s6[5] <= op.n1.re * op.den.im;
			pp_s6[6] <= op.t.re * op.den.re;
			pp_s6[7] <= op.t.im * op.den.im;
			pp_s6[8] <= op.t.im * op.den.re;
			pp_s6[9] <= op.t.re * op.den.im;
		end
	end

	always_comb begin
		rsat = 1'b0;
		for (int i = 0; i < NP; i++) begin
			rnd[i] = bca_pkg::q_round(pp_s6[i]);
			rsat   = rsat | rnd[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			sat_s7  <= rsat;
			for (int i = 0; i < NP; i++) begin
				rp_s7[i] <= rnd[i].val;
			end
		end
	end

	always_comb begin
		dsum = bca_pkg::q_addsub(rp_s7[0], rp_s7[1], 1'b0);
		n1re = bca_pkg::q_addsub(rp_s7[2], rp_s7[3], 1'b0);
		n1im = bca_pkg::q_addsub(rp_s7[4], rp_s7[5], 1'b1);
		tre  = bca_pkg::q_addsub(rp_s7[6], rp_s7[7], 1'b0);
		tim  = bca_pkg::q_addsub(rp_s7[8], rp_s7[9], 1'b1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8.kind    <= side_s7.kind;
			side_s8.res     <= side_s7.res;
			side_s8.sat_res <= side_s7.sat_res;
			side_s8.sat_div <= side_s7.sat_div | sat_s7 | dsum.sat | n1re.sat | n1im.sat
				| tre.sat | tim.sat;
			den_s8          <= dsum.val;
			num_s8          <= {n1re.val, n1im.val, tre.val, tim.val};
		end
	end

	assign den      = den_s8;
	assign num      = num_s8;
	assign side_out = side_s8;

endmodule

// File: design/bca_div.sv
// Pipelined restoring divider for one real Q16.16 quotient with rounding,
// saturation and zero-divisor handling, one quotient bit per stage. Depends on bca_pkg.
module bca_div (
	input  logic        clk,
	input  logic        en,
	input  bca_pkg::q_t num,
	input  bca_pkg::q_t den,
	output bca_pkg::q_t quo,
	output logic        sat,
	output logic        dz
);

	localparam int unsigned QW    = bca_pkg::QW;
	localparam int unsigned NUM_W = bca_pkg::NUM_W;
	localparam int unsigned NIT   = bca_pkg::DIV_ITER;

	// The divisor is a sum of two squares and never negative, so its sign bit is dropped.
	logic [NUM_W-1:0] nq_s  [0:NIT];
	logic [QW-2:0]    rem_s [0:NIT];
	logic [QW-2:0]    den_s [0:NIT];
	logic             neg_s [0:NIT];
	logic             dz_s  [0:NIT];

	logic [QW-1:0]  absn;
	bca_pkg::qres_t fin;
	bca_pkg::q_t    quo_sf;
	logic           sat_sf, dz_sf;

	assign absn = num[QW-1] ? QW'(-num) : QW'(num);

	// Adding half the divisor up front gives round-to-nearest on the magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			nq_s[0]  <= {absn, {bca_pkg::FRAC_W{1'b0}}} + NUM_W'(den[QW-2:1]);
			rem_s[0] <= '0;
			den_s[0] <= den[QW-2:0];
			neg_s[0] <= num[QW-1];
			dz_s[0]  <= (den == '0);
		end
	end

	for (genvar k = 1; k <= NIT; k++) begin : g_iter
		logic [QW-1:0] trial;
		logic [QW-1:0] diff;
		logic          ge;

		assign trial = {rem_s[k-1], nq_s[k-1][NUM_W-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[QW-2:0] : trial[QW-2:0];
				nq_s[k]  <= {nq_s[k-1][NUM_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				dz_s[k]  <= dz_s[k-1];
			end
		end
	end

	assign fin = bca_pkg::q_sign_clamp(nq_s[NIT], neg_s[NIT]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_sf <= dz_s[NIT] ? '0 : fin.val;
			sat_sf <= ~dz_s[NIT] & fin.sat;
			dz_sf  <= dz_s[NIT];
		end
	end

	assign quo = quo_sf;
	assign sat = sat_sf;
	assign dz  = dz_sf;

endmodule

// File: design/bca_checker.sv
// Port-level checker for the bicomplex arithmetic unit and its bind statement.
// Depends on bca_pkg for the pipeline depth.
module bca_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [129:0] out_data
);

	localparam int unsigned CNT_W = bca_pkg::CNT_W;

	logic [CNT_W-1:0] cnt_q;
	logic             acc_in, acc_out;

	assign acc_in  = in_valid & in_ready;
	assign acc_out = out_valid & out_ready;

	// Words inside the block: taken but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(acc_in) - CNT_W'(acc_out);
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !$past(out_ready))
		else $error("operand channel stalled without a held result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !out_valid)
		else $error("result word without a pending operand word");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(bca_pkg::PIPE_LAT + 1))
		else $error("more words in flight than the pipeline holds");

endmodule

bind bicomplex_arithmetic_unit bca_checker u_bca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (operand.valid),
	.in_ready  (operand.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  ({result.r_rr, result.r_ri, result.r_ir, result.r_ii,
		result.saturated, result.div_by_zero})
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bicomplex arithmetic unit: random and directed
// operand words, a bit-exact fixed-point predictor and an in-order result check.
// Depends on bca_pkg, the channel interfaces in bca_if and the top level.
module testbench;

	typedef struct {
		longint re;
		longint im;
	} cval_t;

	typedef struct {
		bca_pkg::kind_t kind;
		bca_pkg::q_t    a_rr, a_ri, a_ir, a_ii;
		bca_pkg::q_t    b_rr, b_ri, b_ir, b_ii;
	} op_word_t;

	typedef struct {
		bca_pkg::q_t rr, ri, ir, ii;
		bit sat;
		bit dz;
	} res_word_t;

	localparam longint LMAX = 64'sd2147483647;
	localparam longint LMIN = -64'sd2147483648;
	localparam int     PAUSE_AT = 600;
	localparam int     LONG_HOLD_AT = 250;
	localparam int     TAIL_LEN = 150;

	logic clk;
	logic arst_n;

	bca_in_if  op_ch();
	bca_out_if res_ch();

	bicomplex_arithmetic_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(op_ch),
		.result (res_ch)
	);

	op_word_t  pending_ops[$];
	res_word_t expected_res[$];
	op_word_t  held_op;
	bit        sat_flag;
	bit        dz_flag;
	int        errors;
	int        sent;
	int        received;
	int        send_gap;
	int        recv_gap;
	int        long_hold;
	bit        long_hold_done;
	logic      tail;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	assign tail = (pending_ops.size() < TAIL_LEN);

	// Fixed-point predictor. Flags are collected across one word's operations.
	function automatic longint clamp_q(longint v);
		if (v > LMAX) begin
			sat_flag = 1'b1;
			return LMAX;
		end
		if (v < LMIN) begin
			sat_flag = 1'b1;
			return LMIN;
		end
		return v;
	endfunction

	function automatic longint q_mul(longint x, longint y);
		longint p;
		longint m;
		p = x * y;
		m = ((p < 0 ? -p : p) + 32768) >>> 16;
		return clamp_q(p < 0 ? -m : m);
	endfunction

	function automatic longint q_div(longint n, longint d);
		longint un;
		longint ud;
		longint q;
		if (d == 0) begin
			dz_flag = 1'b1;
			return 0;
		end
		un = (n < 0 ? -n : n) <<< 16;
		ud = d < 0 ? -d : d;
		q  = (un + ud / 2) / ud;
		return clamp_q(((n < 0) != (d < 0)) ? -q : q);
	endfunction

	function automatic cval_t c_add(cval_t x, cval_t y);
		cval_t r;
		r.re = clamp_q(x.re + y.re);
		r.im = clamp_q(x.im + y.im);
		return r;
	endfunction

	function automatic cval_t c_sub(cval_t x, cval_t y);
		cval_t r;
		r.re = clamp_q(x.re - y.re);
		r.im = clamp_q(x.im - y.im);
		return r;
	endfunction

	function automatic cval_t c_mul(cval_t x, cval_t y);
		cval_t r;
		r.re = clamp_q(q_mul(x.re, y.re) - q_mul(x.im, y.im));
		r.im = clamp_q(q_mul(x.re, y.im) + q_mul(x.im, y.re));
		return r;
	endfunction

	function automatic cval_t c_div(cval_t x, cval_t y);
		cval_t r;
		longint den;
		longint t;
		den  = clamp_q(q_mul(y.re, y.re) + q_mul(y.im, y.im));
		t    = clamp_q(q_mul(x.im, y.re) - q_mul(x.re, y.im));
		r.re = q_div(clamp_q(q_mul(x.re, y.re) + q_mul(x.im, y.im)), den);
		r.im = q_div(t, den);
		return r;
	endfunction

	function automatic res_word_t predict_result(op_word_t op);
		cval_t x1, x2, y1, y2, r1, r2, den, t;
		res_word_t res;
		sat_flag = 1'b0;
		dz_flag  = 1'b0;
		x1 = '{longint'(op.a_rr), longint'(op.a_ri)};
		x2 = '{longint'(op.a_ir), longint'(op.a_ii)};
		y1 = '{longint'(op.b_rr), longint'(op.b_ri)};
		y2 = '{longint'(op.b_ir), longint'(op.b_ii)};
		case (op.kind)
			bca_pkg::KIND_ADD: begin
				r1 = c_add(x1, y1);
				r2 = c_add(x2, y2);
			end
			bca_pkg::KIND_SUB: begin
				r1 = c_sub(x1, y1);
				r2 = c_sub(x2, y2);
			end
			bca_pkg::KIND_MUL: begin
				r1 = c_sub(c_mul(x1, y1), c_mul(x2, y2));
				r2 = c_add(c_mul(x1, y2), c_mul(x2, y1));
			end
			default: begin
				den = c_add(c_mul(y1, y1), c_mul(y2, y2));
				t   = c_sub(c_mul(x2, y1), c_mul(x1, y2));
				r1  = c_div(c_add(c_mul(x1, y1), c_mul(x2, y2)), den);
				r2  = c_div(t, den);
			end
		endcase
		res.rr  = bca_pkg::q_t'(r1.re);
		res.ri  = bca_pkg::q_t'(r1.im);
		res.ir  = bca_pkg::q_t'(r2.re);
		res.ii  = bca_pkg::q_t'(r2.im);
		res.sat = sat_flag;
		res.dz  = dz_flag;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic queue_op(bca_pkg::kind_t k, bca_pkg::q_t a0, bca_pkg::q_t a1,
		bca_pkg::q_t a2, bca_pkg::q_t a3, bca_pkg::q_t b0, bca_pkg::q_t b1,
		bca_pkg::q_t b2, bca_pkg::q_t b3);
		pending_ops.push_back('{k, a0, a1, a2, a3, b0, b1, b2, b3});
	endtask

	// Mostly small values so that products and quotients stay in range; the rest are
	// random words over the full range or the two extremes.
	function automatic bca_pkg::q_t rand_comp(int mode);
		case (mode)
			0: return bca_pkg::q_t'($urandom);
			1: return bca_pkg::q_t'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			2: return bca_pkg::q_t'($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
			default: return ($urandom_range(0, 1) != 0) ? bca_pkg::QMAX : bca_pkg::QMIN;
		endcase
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		op_word_t nxt;
		if (!arst_n) begin
			op_ch.valid <= 1'b0;
			op_ch.kind  <= bca_pkg::KIND_ADD;
			op_ch.a_rr  <= '0;
			op_ch.a_ri  <= '0;
			op_ch.a_ir  <= '0;
			op_ch.a_ii  <= '0;
			op_ch.b_rr  <= '0;
			op_ch.b_ri  <= '0;
			op_ch.b_ir  <= '0;
			op_ch.b_ii  <= '0;
			send_gap    <= 0;
			sent        <= 0;
		end else begin
			if (op_ch.valid && op_ch.ready)
				expected_res.push_back(predict_result(held_op));
			if (!op_ch.valid || op_ch.ready) begin
				if (send_gap > 0) begin
					send_gap    <= send_gap - 1;
					op_ch.valid <= 1'b0;
				end else if (sent == PAUSE_AT && expected_res.size() != 0) begin
					// Let the pipeline drain completely before going on.
					op_ch.valid <= 1'b0;
				end else if (pending_ops.size() == 0) begin
					op_ch.valid <= 1'b0;
				end else if (!tail && $urandom_range(0, 5) == 0) begin
					send_gap    <= $urandom_range(0, 3);
					op_ch.valid <= 1'b0;
				end else begin
					nxt = pending_ops.pop_front();
					held_op     <= nxt;
					op_ch.valid <= 1'b1;
					op_ch.kind  <= nxt.kind;
					op_ch.a_rr  <= nxt.a_rr;
					op_ch.a_ri  <= nxt.a_ri;
					op_ch.a_ir  <= nxt.a_ir;
					op_ch.a_ii  <= nxt.a_ii;
					op_ch.b_rr  <= nxt.b_rr;
					op_ch.b_ri  <= nxt.b_ri;
					op_ch.b_ir  <= nxt.b_ir;
					op_ch.b_ii  <= nxt.b_ii;
					sent        <= sent + 1;
				end
			end
		end
	end

	// Long receiver hold, long enough for the pipeline and skid register to fill.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold      <= 0;
			long_hold_done <= 1'b0;
		end else if (!long_hold_done && received == LONG_HOLD_AT) begin
			long_hold_done <= 1'b1;
			long_hold      <= 150;
		end else if (long_hold > 0) begin
			long_hold <= long_hold - 1;
		end
	end

	// Monitor and receiver.
	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		if (!arst_n) begin
			res_ch.ready   <= 1'b0;
			recv_gap       <= 0;
			received       <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				received <= received + 1;
				if (expected_res.size() == 0) begin
					$display("%0t: result word with no expectation pending", $realtime);
					errors++;
				end else begin
					want = expected_res.pop_front();
					if (res_ch.r_rr !== want.rr) report_mismatch("r_rr", res_ch.r_rr, want.rr);
					if (res_ch.r_ri !== want.ri) report_mismatch("r_ri", res_ch.r_ri, want.ri);
					if (res_ch.r_ir !== want.ir) report_mismatch("r_ir", res_ch.r_ir, want.ir);
					if (res_ch.r_ii !== want.ii) report_mismatch("r_ii", res_ch.r_ii, want.ii);
					if (res_ch.saturated !== want.sat)
						report_mismatch("saturated", res_ch.saturated, want.sat);
					if (res_ch.div_by_zero !== want.dz)
						report_mismatch("div_by_zero", res_ch.div_by_zero, want.dz);
				end
			end
			if (long_hold > 0) begin
				res_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap     <= recv_gap - 1;
				res_ch.ready <= 1'b0;
			end else if (!tail && $urandom_range(0, 5) == 0) begin
				recv_gap     <= $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int mode;
		errors = 0;
		arst_n = 1'b0;

		// Extremes, every operation, ties in rounding, and zero divisors.
		for (int k = 0; k < 4; k++) begin
			queue_op(bca_pkg::kind_t'(k), bca_pkg::QMAX, bca_pkg::QMAX, bca_pkg::QMAX,
				bca_pkg::QMAX, bca_pkg::QMAX, bca_pkg::QMAX, bca_pkg::QMAX, bca_pkg::QMAX);
			queue_op(bca_pkg::kind_t'(k), bca_pkg::QMIN, bca_pkg::QMIN, bca_pkg::QMIN,
				bca_pkg::QMIN, bca_pkg::QMAX, bca_pkg::QMIN, bca_pkg::QMAX, bca_pkg::QMIN);
			queue_op(bca_pkg::kind_t'(k), bca_pkg::QMAX, bca_pkg::QMIN, 0, -1,
				bca_pkg::QMIN, bca_pkg::QMAX, -1, 1);
			queue_op(bca_pkg::kind_t'(k), 32'sh10000, -32'sh20000, 32'sh8000, 1,
				32'sh30000, 32'sh10000, -32'sh10000, 32'sh4000);
		end
		queue_op(bca_pkg::KIND_MUL, 1, 1, 1, 1, 32'sh8000, 0, 0, 0);
		queue_op(bca_pkg::KIND_MUL, -1, 3, -3, 1, 32'sh8000, 0, 0, 0);
		// Zero divisor, real scalar divisor, and divisors that vanish.
		queue_op(bca_pkg::KIND_DIV, 32'sh10000, 2, 3, 4, 0, 0, 0, 0);
		queue_op(bca_pkg::KIND_DIV, 32'sh50000, -32'sh30000, 7, -9, 32'sh30000, 0, 0, 0);
		queue_op(bca_pkg::KIND_DIV, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
			32'sh10000, 0, 0, 32'sh10000);
		queue_op(bca_pkg::KIND_DIV, 32'sh10000, 32'sh10000, 0, 0, 1, 1, 1, 1);
		queue_op(bca_pkg::KIND_DIV, bca_pkg::QMAX, bca_pkg::QMIN, bca_pkg::QMAX,
			bca_pkg::QMIN, 32'sh100, 0, 0, 0);
		queue_op(bca_pkg::KIND_DIV, 32'sh18000, -32'sh8000, 1, 0, 32'sh20000, 0, 0, 0);

		for (int n = 0; n < 900; n++) begin
			mode = $urandom_range(0, 9);
			mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
			queue_op(bca_pkg::kind_t'($urandom_range(0, 3)),
				rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
				rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && !op_ch.valid && expected_res.size() == 0);
		repeat (80) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
